// ===== rtl/mmcs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmcs_pkg
// Shared constants and controller/datapath interface types for the min-max
// contrast stretch block.
// ----------------------------------------------------------------------------
package mmcs_pkg;

    // Port width of a pixel on both streams
    localparam int DATA_BITS  = 16;
    // Significant pixel bits (8 to 16); upper port bits are ignored
    localparam int PIXEL_BITS = 16;
    // Full-scale output value
    localparam logic [PIXEL_BITS-1:0] FULL_SCALE = {PIXEL_BITS{1'b1}};
    // Divider step counter width: one quotient bit per step
    localparam int STEP_BITS  = (PIXEL_BITS > 1) ? $clog2(PIXEL_BITS) : 1;
    localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(PIXEL_BITS - 1);

    // Commands from controller to datapath
    typedef struct packed {
        logic accept_measure;  // measure pixel taken: update min/max
        logic accept_convert;  // convert pixel taken: capture operands
        logic load_mul;        // form scaled numerator, seed divider
        logic div_step;        // one restoring division step
        logic load_out;        // write result into output register
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic bypass;    // flat range or saturated pixel: no division needed
        logic out_free;  // output register can take a new result this cycle
    } t_dp_sts;

endpackage : mmcs_pkg
`default_nettype wire

// ===== rtl/min_max_contrast_stretch.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// min_max_contrast_stretch
// Two-pass min-max contrast stretch of 16-bit infrared pixels to full scale.
//
//  Channel  Dir  tdata (low bit up)   tuser        tlast
//  s_       in   pixel_in[15:0]       action       end_of_pass
//  m_       out  gray_out[15:0]       flat_frame   last_out
//
// Measure pixels are taken one per cycle while no convert pixel is in
// progress. A convert pixel occupies the block through the scaling, division
// and output states, the restoring divider producing one quotient bit per
// cycle; flat or saturated pixels skip the division. The output register lets
// the next pixel in while a result waits on m_tready. Reset is synchronous
// and active low; there is no clearing pass.
// ----------------------------------------------------------------------------
module min_max_contrast_stretch (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // Fields: pixel_in[15:0]
    input  wire logic [mmcs_pkg::DATA_BITS-1:0] s_tdata,
    // Fields: action
    input  wire logic                           s_tuser,
    input  wire logic                           s_tlast,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // Fields: gray_out[15:0]
    output logic [mmcs_pkg::DATA_BITS-1:0]      m_tdata,
    // Fields: flat_frame
    output logic                                m_tuser,
    output logic                                m_tlast,
    output logic                                m_tvalid,
    input  wire logic                           m_tready
);
    import mmcs_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // Sequencer
    mmcs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .i_action   (s_tuser),
        .i_sts      (w_sts),
        .o_s_tready (s_tready),
        .o_cmd      (w_cmd)
    );

    // Tracking, divider and output register
    mmcs_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_pixel    (s_tdata),
        .i_last     (s_tlast),
        .i_m_tready (m_tready),
        .o_sts      (w_sts),
        .o_m_tvalid (m_tvalid),
        .o_gray     (m_tdata),
        .o_flat     (m_tuser),
        .o_last     (m_tlast)
    );

    // A convert transaction blocks input on the next cycle
    a_convert_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready && s_tuser) |=> !s_tready)
        else $error("input taken during a convert");

    // A result is only written into a free output register
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |-> w_sts.out_free)
        else $error("output register overwritten");

    // A measure transaction raises no result
    a_measure_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready && !s_tuser && !m_tvalid) |=> !m_tvalid)
        else $error("result raised by a measure pixel");

    // Input is never taken while a result is being loaded
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |-> !s_tready)
        else $error("input and result load overlap");

endmodule : min_max_contrast_stretch
`default_nettype wire

// ===== rtl/mmcs_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmcs_ctrl
// Sequencer for the contrast stretch: takes pixels, steps the datapath
// through scaling and the iterative division, and hands the result over.
// ----------------------------------------------------------------------------
module mmcs_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_tvalid,
    input  wire logic              i_action,
    input  wire mmcs_pkg::t_dp_sts i_sts,
    output logic                   o_s_tready,
    output mmcs_pkg::t_dp_cmd      o_cmd
);
    import mmcs_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_OUT  = 4'b1000
    } t_state;

    t_state               r_state, n_state;
    logic [STEP_BITS-1:0] r_step,  n_step;
    logic                 w_accept;

    assign o_s_tready = (r_state == ST_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;

    // Decode state into datapath commands and next state
    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_step  = r_step;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.accept_measure = w_accept && !i_action;
                o_cmd.accept_convert = w_accept && i_action;
                if (w_accept && i_action) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                o_cmd.load_mul = 1'b1;
                n_step         = '0;
                n_state        = i_sts.bypass ? ST_OUT : ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_step         = r_step + 1'b1;
                if (r_step == LAST_STEP) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                // Hold until the output register is free
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Advance state and step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

endmodule : mmcs_ctrl
`default_nettype wire

// ===== rtl/mmcs_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmcs_datapath
// Min/max tracking, operand capture, restoring divider and output register
// for the contrast stretch.
// ----------------------------------------------------------------------------
module mmcs_datapath (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire mmcs_pkg::t_dp_cmd            i_cmd,
    input  wire logic [mmcs_pkg::DATA_BITS-1:0] i_pixel,
    input  wire logic                         i_last,
    input  wire logic                         i_m_tready,
    output mmcs_pkg::t_dp_sts                 o_sts,
    output logic                              o_m_tvalid,
    output logic [mmcs_pkg::DATA_BITS-1:0]    o_gray,
    output logic                              o_flat,
    output logic                              o_last
);
    import mmcs_pkg::*;

    localparam int PB = PIXEL_BITS;

    // Tracking state
    logic [PB-1:0]   r_low,   n_low;
    logic [PB-1:0]   r_high,  n_high;
    logic            r_restart, n_restart;

    // Captured convert operands
    logic [PB-1:0]   r_pix;
    logic [PB-1:0]   r_x;
    logic [PB-1:0]   r_d;
    logic            r_flat, r_lsat, r_hsat, r_last;

    // Divider
    logic [PB-1:0]   r_rem, n_rem;
    logic [PB-1:0]   r_quo, n_quo;
    logic [2*PB-1:0] w_prod;
    logic [PB:0]     w_trial;
    logic [PB:0]     w_diff;

    // Output register
    logic            r_out_valid, n_out_valid;
    logic [PB-1:0]   r_gray, n_gray;
    logic            r_oflat, r_olast;

    logic [PB-1:0]   w_p;

    assign w_p = i_pixel[PB-1:0];

    // Update min/max on measure pixels; a convert pixel or a measure tlast arms a restart
    always_comb begin
        n_low     = r_low;
        n_high    = r_high;
        n_restart = r_restart;
        if (i_cmd.accept_measure) begin
            if (r_restart) begin
                n_low     = w_p;
                n_high    = w_p;
                n_restart = 1'b0;
            end else begin
                if (w_p < r_low) begin
                    n_low = w_p;
                end
                if (w_p > r_high) begin
                    n_high = w_p;
                end
            end
            if (i_last) begin
                n_restart = 1'b1;
            end
        end else if (i_cmd.accept_convert) begin
            n_restart = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low     <= FULL_SCALE;
            r_high    <= '0;
            r_restart <= 1'b1;
        end else begin
            r_low     <= n_low;
            r_high    <= n_high;
            r_restart <= n_restart;
        end
    end

    // Capture offset, range and special-case flags of a convert pixel
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept_convert) begin
            r_pix  <= w_p;
            r_x    <= w_p - r_low;
            r_d    <= r_high - r_low;
            r_flat <= (r_high <= r_low);
            r_lsat <= (w_p <= r_low);
            r_hsat <= (w_p >= r_high);
            r_last <= i_last;
        end
    end

    // Numerator x * FULL_SCALE as (x << PB) - x; the upper half seeds the
    // remainder, which stays below the range because x < range
    assign w_prod  = {r_x, {PB{1'b0}}} - {{PB{1'b0}}, r_x};
    assign w_trial = {r_rem, r_quo[PB-1]};
    assign w_diff  = w_trial - {1'b0, r_d};

    // Restoring division, one quotient bit per step
    always_comb begin
        n_rem = r_rem;
        n_quo = r_quo;
        if (i_cmd.load_mul) begin
            n_rem = w_prod[2*PB-1:PB];
            n_quo = w_prod[PB-1:0];
        end else if (i_cmd.div_step) begin
            if (!w_diff[PB]) begin
                n_rem = w_diff[PB-1:0];
                n_quo = {r_quo[PB-2:0], 1'b1};
            end else begin
                n_rem = w_trial[PB-1:0];
                n_quo = {r_quo[PB-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
    end

    // Select result: flat passes raw, then saturation, then quotient
    always_comb begin
        priority if (r_flat) begin
            n_gray = r_pix;
        end else if (r_lsat) begin
            n_gray = '0;
        end else if (r_hsat) begin
            n_gray = FULL_SCALE;
        end else begin
            n_gray = r_quo;
        end
    end

    // Hold result until taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (i_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_gray  <= n_gray;
            r_oflat <= r_flat;
            r_olast <= r_last;
        end
    end

    assign o_sts.bypass   = r_flat || r_lsat || r_hsat;
    assign o_sts.out_free = !r_out_valid || i_m_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_gray     = DATA_BITS'(r_gray);
    assign o_flat     = r_oflat;
    assign o_last     = r_olast;

endmodule : mmcs_datapath
`default_nettype wire

// ===== sim/stretch_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stretch_checker
// Watches both streams of the contrast stretch block. It keeps its own copy of
// the running minimum and maximum, predicts the stretched pixel for every
// convert transaction, and compares each output transaction with the oldest
// prediction, field by field.
// ----------------------------------------------------------------------------
module stretch_checker (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // Fields: pixel_in[15:0]
    input  wire logic [mmcs_pkg::DATA_BITS-1:0] i_s_tdata,
    // Fields: action
    input  wire logic                           i_s_tuser,
    input  wire logic                           i_s_tlast,
    input  wire logic                           i_s_tvalid,
    input  wire logic                           i_s_tready,
    // Fields: gray_out[15:0]
    input  wire logic [mmcs_pkg::DATA_BITS-1:0] i_m_tdata,
    // Fields: flat_frame
    input  wire logic                           i_m_tuser,
    input  wire logic                           i_m_tlast,
    input  wire logic                           i_m_tvalid,
    input  wire logic                           i_m_tready,
    output int                                  o_fail_count,
    output int                                  o_results_pending
);
    import mmcs_pkg::*;

    localparam int WIDE_BITS = 2 * PIXEL_BITS;

    typedef struct packed {
        logic [DATA_BITS-1:0] gray;
        logic                 flat;
        logic                 last;
    } t_stretched_pixel;

    logic [PIXEL_BITS-1:0] lowest_seen     = FULL_SCALE;
    logic [PIXEL_BITS-1:0] highest_seen    = '0;
    logic                  restart_pending = 1'b1;
    t_stretched_pixel      stretched_q[$];
    int                    mismatches      = 0;

    // Map one pixel onto the full range measured so far
    function automatic t_stretched_pixel stretch_pixel(input logic [PIXEL_BITS-1:0] level,
                                                       input logic                  last);
        t_stretched_pixel      res;
        logic [WIDE_BITS-1:0]  scaled;
        res.last = last;
        res.flat = 1'b0;
        if (highest_seen <= lowest_seen) begin
            // empty or flat range: pass the pixel through
            res.flat = 1'b1;
            res.gray = DATA_BITS'(level);
        end else if (level <= lowest_seen) begin
            res.gray = '0;
        end else if (level >= highest_seen) begin
            res.gray = DATA_BITS'(FULL_SCALE);
        end else begin
            scaled   = WIDE_BITS'(level - lowest_seen) * WIDE_BITS'(FULL_SCALE);
            res.gray = DATA_BITS'(scaled / WIDE_BITS'(highest_seen - lowest_seen));
        end
        return res;
    endfunction

    // Predict on input transactions, compare on output transactions
    always @(posedge i_clk) begin : track_and_compare
        t_stretched_pixel      expected;
        logic [PIXEL_BITS-1:0] level;
        if (!i_rst_n) begin
            lowest_seen     = FULL_SCALE;
            highest_seen    = '0;
            restart_pending = 1'b1;
            stretched_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (stretched_q.size() == 0) begin
                    $error("unexpected result: gray_out %0d, flat_frame %0b, last_out %0b",
                           i_m_tdata, i_m_tuser, i_m_tlast);
                    mismatches++;
                end else begin
                    expected = stretched_q.pop_front();
                    if (i_m_tdata !== expected.gray) begin
                        $error("gray_out: expected %0d, actual %0d", expected.gray, i_m_tdata);
                        mismatches++;
                    end
                    if (i_m_tuser !== expected.flat) begin
                        $error("flat_frame: expected %0b, actual %0b", expected.flat, i_m_tuser);
                        mismatches++;
                    end
                    if (i_m_tlast !== expected.last) begin
                        $error("last_out: expected %0b, actual %0b", expected.last, i_m_tlast);
                        mismatches++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                level = i_s_tdata[PIXEL_BITS-1:0];
                if (i_s_tuser) begin
                    // convert pixel: one result, and the next measure restarts
                    stretched_q.push_back(stretch_pixel(level, i_s_tlast));
                    restart_pending = 1'b1;
                end else begin
                    if (restart_pending) begin
                        lowest_seen     = level;
                        highest_seen    = level;
                        restart_pending = 1'b0;
                    end else begin
                        if (level < lowest_seen)
                            lowest_seen = level;
                        if (level > highest_seen)
                            highest_seen = level;
                    end
                    if (i_s_tlast)
                        restart_pending = 1'b1;
                end
            end
        end
        o_fail_count      <= mismatches;
        o_results_pending <= stretched_q.size();
    end

endmodule : stretch_checker

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams measure and convert passes into the contrast stretch block: a short
// directed set of edge cases, then random frames, mostly well formed with
// some broken passes and stray pixels. The sender bursts with random gaps,
// the receiver stalls in shifting patterns and twice holds off for a long
// stretch. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
    import mmcs_pkg::*;

    localparam int RANDOM_ITEMS  = 1500;
    localparam int SETTLE_CYCLES = 2 * (PIXEL_BITS + 3);

    typedef struct packed {
        logic                 convert;
        logic [DATA_BITS-1:0] pixel;
        logic                 last;
    } t_pixel_item;

    typedef enum int {
        READY_ALWAYS,
        READY_HALF,
        READY_MOSTLY,
        READY_SPARSE
    } t_ready_mode;

    logic                 i_clk    = 1'b0;
    logic                 i_rst_n  = 1'b0;
    logic [DATA_BITS-1:0] s_tdata  = '0;
    logic                 s_tuser  = 1'b0;
    logic                 s_tlast  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [DATA_BITS-1:0] m_tdata;
    logic                 m_tuser;
    logic                 m_tlast;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;

    t_pixel_item pixel_items[$];
    int          send_idx   = 0;
    int          burst_left = 0;
    int          gap_left   = 0;
    logic        all_sent   = 1'b0;
    logic        hold_off   = 1'b0;
    t_ready_mode ready_mode = READY_ALWAYS;
    int          mode_left  = 0;
    logic        ready_draw;
    int          fail_count;
    int          results_pending;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    min_max_contrast_stretch u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    stretch_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_s_tdata         (s_tdata),
        .i_s_tuser         (s_tuser),
        .i_s_tlast         (s_tlast),
        .i_s_tvalid        (s_tvalid),
        .i_s_tready        (s_tready),
        .i_m_tdata         (m_tdata),
        .i_m_tuser         (m_tuser),
        .i_m_tlast         (m_tlast),
        .i_m_tvalid        (m_tvalid),
        .i_m_tready        (m_tready),
        .o_fail_count      (fail_count),
        .o_results_pending (results_pending)
    );

    task automatic add_item(input logic convert, input int unsigned pixel, input logic last);
        pixel_items.push_back('{convert, DATA_BITS'(pixel), last});
    endtask

    function automatic int unsigned pixel_between(input int unsigned lo, input int unsigned hi);
        return $urandom_range(hi, lo);
    endfunction

    // One frame: a measure pass then a convert pass, sometimes broken
    task automatic add_frame();
        int unsigned lo;
        int unsigned hi;
        int unsigned a;
        int unsigned b;
        int          size;
        int          shape;
        logic        last;
        case ($urandom_range(0, 4))
            0: begin
                a  = $urandom_range(0, 65535);
                b  = $urandom_range(0, 65535);
                lo = (a < b) ? a : b;
                hi = (a < b) ? b : a;
            end
            1: begin
                lo = $urandom_range(0, 65535);
                hi = lo + $urandom_range(0, 3);
                if (hi > 65535)
                    hi = 65535;
            end
            2: begin
                lo = 0;
                hi = 65535;
            end
            3: begin
                lo = $urandom_range(0, 65535);
                hi = lo;
            end
            default: begin
                lo = $urandom_range(0, 255);
                hi = $urandom_range(65280, 65535);
            end
        endcase
        size  = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
        shape = $urandom_range(0, 11);

        // stray pixels with every field random
        if (shape == 11) begin
            repeat ($urandom_range(1, 4))
                add_item(1'($urandom_range(0, 1)), $urandom_range(0, 65535),
                         1'($urandom_range(0, 1)));
            return;
        end

        // measure pass: shape 7 drops the closing tlast, shape 8 skips the pass,
        // shape 9 scatters tlast through it
        if (shape != 8) begin
            for (int i = 0; i < size; i++) begin
                last = (i == size - 1) && (shape != 7);
                if (shape == 9 && $urandom_range(0, 3) == 0)
                    last = 1'b1;
                add_item(1'b0, pixel_between(lo, hi), last);
            end
        end

        // convert pass: mostly in range, some pixels anywhere to force saturation
        for (int i = 0; i < size; i++) begin
            last = (i == size - 1);
            if (shape == 10)
                last = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 7) == 0)
                add_item(1'b1, $urandom_range(0, 65535), last);
            else
                add_item(1'b1, pixel_between(lo, hi), last);
        end
    endtask

    // Offer pixels in bursts; hold each one until it is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid && send_idx == pixel_items.size())
                all_sent <= 1'b1;
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (send_idx < pixel_items.size()) begin
                s_tdata  <= pixel_items[send_idx].pixel;
                s_tuser  <= pixel_items[send_idx].convert;
                s_tlast  <= pixel_items[send_idx].last;
                s_tvalid <= 1'b1;
                send_idx++;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 48);
                    case ($urandom_range(0, 5))
                        0, 1:    gap_left = 0;
                        5:       gap_left = $urandom_range(5, 30);
                        default: gap_left = $urandom_range(1, 4);
                    endcase
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Stall the output in shifting patterns
    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            ready_mode = t_ready_mode'($urandom_range(0, 3));
            mode_left  = $urandom_range(32, 256);
        end else begin
            mode_left--;
        end
        case (ready_mode)
            READY_ALWAYS: ready_draw = 1'b1;
            READY_HALF:   ready_draw = 1'($urandom_range(0, 1));
            READY_MOSTLY: ready_draw = ($urandom_range(0, 7) != 0);
            default:      ready_draw = ($urandom_range(0, 3) == 0);
        endcase
        m_tready <= ready_draw && !hold_off;
    end

    // Hold the output off for long stretches so the block backs up its input
    initial begin : long_hold_off
        repeat ($urandom_range(200, 600)) @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (400) @(posedge i_clk);
        hold_off <= 1'b0;
        repeat ($urandom_range(2000, 5000)) @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (250) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    initial begin : run_test
        int directed_count;

        // convert with no measure pass yet: empty range passes pixels through
        add_item(1'b1, 16'h1234, 1'b0);
        add_item(1'b1, 16'hFFFF, 1'b1);
        // single-pixel measure pass: flat range
        add_item(1'b0, 100, 1'b1);
        add_item(1'b1, 100, 1'b0);
        add_item(1'b1, 0, 1'b1);
        // full-range frame, extremes of the pixel field
        add_item(1'b0, 0, 1'b0);
        add_item(1'b0, 65535, 1'b0);
        add_item(1'b0, 32768, 1'b1);
        add_item(1'b1, 0, 1'b0);
        add_item(1'b1, 32767, 1'b0);
        add_item(1'b1, 65535, 1'b1);
        // pixels below and above the measured range saturate
        add_item(1'b0, 1000, 1'b0);
        add_item(1'b0, 2000, 1'b1);
        add_item(1'b1, 999, 1'b0);
        add_item(1'b1, 1500, 1'b0);
        add_item(1'b1, 2001, 1'b1);
        // measure pass closed by a convert pixel instead of tlast
        add_item(1'b0, 5, 1'b0);
        add_item(1'b0, 9, 1'b0);
        add_item(1'b1, 7, 1'b1);
        // range of one
        add_item(1'b0, 30000, 1'b0);
        add_item(1'b0, 30001, 1'b1);
        add_item(1'b1, 30000, 1'b0);
        add_item(1'b1, 30001, 1'b1);
        directed_count = pixel_items.size();

        while (pixel_items.size() < directed_count + RANDOM_ITEMS)
            add_frame();

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (!all_sent)
            @(posedge i_clk);
        while (results_pending != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && results_pending == 0) begin
            $display("min_max_contrast_stretch test passed");
        end else begin
            $display("min_max_contrast_stretch test failed");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("min_max_contrast_stretch test failed");
        $finish;
    end

endmodule : testbench
